[hw/rtl/mwerm_pkg.sv]
// ============================================================================
// mwerm_pkg
// Shared types and constants for the multi-window event rate meter.
// ============================================================================
package mwerm_pkg;

    localparam int unsigned HISTORY_DEPTH_DEF = 1024;
    localparam int unsigned WINDOW_COUNT_DEF  = 7;
    localparam int unsigned FRACTION_BITS_DEF = 8;
    localparam int unsigned MAX_WINDOWS       = 7;
    localparam int unsigned RATE_W            = 28;
    localparam int unsigned TIME_W            = 32;
    localparam int unsigned WIN_W             = 16;
    localparam int unsigned IDX_W             = 3;
    localparam int unsigned MS_PER_S          = 1000;

    localparam logic [3:0] REG_REFRESH = 4'd7;

    localparam logic [WIN_W-1:0] WINDOW_RESET [MAX_WINDOWS] = '{
        16'd1000, 16'd2000, 16'd3000, 16'd5000, 16'd10000, 16'd20000, 16'd30000
    };
    localparam logic [WIN_W-1:0] REFRESH_RESET = 16'd100;

    localparam logic MODE_PRESS = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;

    // Entry of the queue between the front and the back.
    typedef struct packed {
        logic              mode;
        logic [TIME_W-1:0] time_ms;
    } item_t;

endpackage

[hw/rtl/mwerm_ram.sv]
// ============================================================================
// mwerm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module mwerm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hw/rtl/mwerm_front.sv]
// ============================================================================
// mwerm_front
// Input queue: accepts items and holds up to two for the back end.
// ============================================================================
module mwerm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  mwerm_pkg::item_t  in_item,
    output logic              q_valid,
    input  logic              q_pop,
    output mwerm_pkg::item_t  q_item
);
    import mwerm_pkg::*;

    item_t      slot_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    logic       push;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (q_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= in_item;
        end
    end
endmodule

[hw/rtl/mwerm_divider.sv]
// ============================================================================
// mwerm_divider
// Restoring divider, one quotient bit per cycle, saturating to the rate width.
// ============================================================================
module mwerm_divider #(
    parameter int unsigned NUM_W = 44
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [NUM_W-1:0]                num,
    input  logic [mwerm_pkg::WIN_W-1:0]     den,
    output logic                            done,
    output logic [mwerm_pkg::RATE_W-1:0]    quot
);
    import mwerm_pkg::*;

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [WIN_W:0]   rem_reg;
    logic [WIN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [WIN_W:0]   trial;
    logic [WIN_W:0]   shifted;

    assign shifted = {rem_reg[WIN_W-1:0], q_reg[NUM_W-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign done    = busy_reg && (cnt_reg == '0);
    always_comb
    begin
        if (NUM_W > RATE_W && |(q_reg >> RATE_W))
        begin
            quot = '1;
        end
        else
        begin
            quot = q_reg[RATE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= (den == '0) ? WIN_W'(1) : den;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            if (!trial[WIN_W])
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end
endmodule

[hw/rtl/mwerm_back.sv]
// ============================================================================
// mwerm_back
// Executes queued items: stores presses, walks the ring for each window on
// an evaluate, divides, updates rates and issues one result per window.
// ============================================================================
module mwerm_back #(
    parameter int unsigned HISTORY_DEPTH = mwerm_pkg::HISTORY_DEPTH_DEF,
    parameter int unsigned WINDOW_COUNT  = mwerm_pkg::WINDOW_COUNT_DEF,
    parameter int unsigned FRACTION_BITS = mwerm_pkg::FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  mwerm_pkg::item_t              q_item,
    input  logic [mwerm_pkg::WIN_W-1:0]   win_len [mwerm_pkg::MAX_WINDOWS],
    input  logic [mwerm_pkg::WIN_W-1:0]   refresh_period,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mwerm_pkg::IDX_W-1:0]   window_index,
    output logic [mwerm_pkg::RATE_W-1:0]  current_rate,
    output logic [mwerm_pkg::RATE_W-1:0]  peak_rate,
    output logic                          last,
    output logic                          busy
);
    import mwerm_pkg::*;

    localparam int unsigned AW    = $clog2(HISTORY_DEPTH);
    localparam int unsigned CW    = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned NUM_W = CW + 10 + FRACTION_BITS;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_CMP, ST_MUL, ST_DIV, ST_OUT
    } state_t;

    state_t            state_reg;
    logic [AW-1:0]     wp_reg;
    logic [CW-1:0]     stored_reg;
    logic [CW-1:0]     n_reg;
    logic [AW-1:0]     pos_reg;
    logic [IDX_W-1:0]  win_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] last_ref_reg;
    logic              refresh_reg;
    logic [RATE_W-1:0] cur_reg [MAX_WINDOWS];
    logic [RATE_W-1:0] peak_reg [MAX_WINDOWS];
    logic [NUM_W-1:0]  num_reg;
    logic              div_start;
    logic              div_done;
    logic [RATE_W-1:0] div_q;
    logic [TIME_W-1:0] stamp;
    logic              ram_we;
    logic [WIN_W-1:0]  win;
    logic              out_valid_reg;

    assign win       = win_len[win_reg];
    assign ram_we    = (state_reg == ST_IDLE) && q_valid && (q_item.mode == MODE_PRESS);
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign div_start = (state_reg == ST_MUL);
    assign out_valid = out_valid_reg;
    assign busy      = (state_reg != ST_IDLE) || q_valid;

    mwerm_ram #(.WIDTH(TIME_W), .DEPTH(HISTORY_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (q_item.time_ms),
        .raddr (pos_reg),
        .rdata (stamp)
    );

    mwerm_divider #(.NUM_W(NUM_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (win),
        .done  (div_done),
        .quot  (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            stored_reg    <= '0;
            last_ref_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_WINDOWS; i++)
            begin
                cur_reg[i]  <= '0;
                peak_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_item.mode == MODE_PRESS)
                        begin
                            wp_reg <= (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                            if (stored_reg != CW'(HISTORY_DEPTH))
                            begin
                                stored_reg <= stored_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            now_reg     <= q_item.time_ms;
                            refresh_reg <= q_item.time_ms >
                                           (last_ref_reg + TIME_W'(refresh_period));
                            win_reg     <= '0;
                            n_reg       <= '0;
                            pos_reg     <= (wp_reg == '0) ? AW'(HISTORY_DEPTH - 1)
                                                          : wp_reg - 1'b1;
                            state_reg   <= ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    if (n_reg == stored_reg)
                    begin
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP:
                begin
                    if ((stamp + TIME_W'(win)) < now_reg)
                    begin
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        n_reg     <= n_reg + 1'b1;
                        pos_reg   <= (pos_reg == '0) ? AW'(HISTORY_DEPTH - 1)
                                                     : pos_reg - 1'b1;
                        state_reg <= ST_READ;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        if (div_q > peak_reg[win_reg])
                        begin
                            peak_reg[win_reg] <= div_q;
                        end
                        if (refresh_reg)
                        begin
                            cur_reg[win_reg] <= div_q;
                        end
                        window_index  <= win_reg;
                        current_rate  <= refresh_reg ? div_q : cur_reg[win_reg];
                        peak_rate     <= (div_q > peak_reg[win_reg]) ? div_q
                                                                      : peak_reg[win_reg];
                        last          <= (win_reg == IDX_W'(WINDOW_COUNT - 1));
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (win_reg == IDX_W'(WINDOW_COUNT - 1))
                        begin
                            if (refresh_reg)
                            begin
                                last_ref_reg <= now_reg;
                            end
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            win_reg   <= win_reg + 1'b1;
                            n_reg     <= '0;
                            pos_reg   <= (wp_reg == '0) ? AW'(HISTORY_DEPTH - 1)
                                                        : wp_reg - 1'b1;
                            state_reg <= ST_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Count times 1000 times 2^FRACTION_BITS, registered ahead of the divider.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ || state_reg == ST_CMP)
        begin
            num_reg <= (NUM_W'(n_reg) * NUM_W'(MS_PER_S)) << FRACTION_BITS;
        end
    end
endmodule

[hw/rtl/multi_window_event_rate_meter_top.sv]
// ============================================================================
// multi_window_event_rate_meter_top
// Sliding-window press rate meter over up to seven configurable windows.
// ============================================================================
// Usage: the input channel (in_valid, in_stall, mode, time_ms) carries one
// transfer per item. Mode 0 records a press timestamp in a ring of the newest
// HISTORY_DEPTH stamps; mode 1 evaluates the rates at time_ms. A press makes
// no result. An evaluate makes WINDOW_COUNT result transfers on the output
// channel (out_valid, out_stall), one per window in order, with last set on
// the final one. Rates are presses per second with FRACTION_BITS fraction
// bits; peaks only ever rise, current rates follow the refresh period.
// Flow: a press is held in a queue slot, then written to the ring when the
// back end pops it, without leaving its idle state. For each window the back
// end walks the ring one stamp at a time (a RAM read, then a compare), up to
// the first stamp outside the window, then forms the numerator and runs a
// one-bit-per-cycle divider. A two-entry queue sits in front, so items are
// taken while the back works.
// Reset clears counts, pointers, rates and the refresh time and loads the
// default windows; stamps are not cleared since only written ones are read.
// When the receiver stalls, the current result holds and the walk pauses.
// Registers sit at byte address 4*i on the APB port: windows, then period.
// ============================================================================
module multi_window_event_rate_meter_top #(
    parameter int unsigned HISTORY_DEPTH = mwerm_pkg::HISTORY_DEPTH_DEF,
    parameter int unsigned WINDOW_COUNT  = mwerm_pkg::WINDOW_COUNT_DEF,
    parameter int unsigned FRACTION_BITS = mwerm_pkg::FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [mwerm_pkg::TIME_W-1:0]  time_ms,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mwerm_pkg::IDX_W-1:0]   window_index,
    output logic [mwerm_pkg::RATE_W-1:0]  current_rate,
    output logic [mwerm_pkg::RATE_W-1:0]  peak_rate,
    output logic                          last
);
    import mwerm_pkg::*;

    logic [WIN_W-1:0] win_reg [MAX_WINDOWS];
    logic [WIN_W-1:0] refresh_reg;
    logic [3:0]       reg_idx;
    item_t            in_item;
    item_t            q_item;
    logic             q_valid;
    logic             q_pop;
    logic             back_busy;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2] == 3'd7 ? REG_REFRESH : {1'b0, paddr[4:2]};

    // Register file; writes land on the access phase of the APB transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WINDOWS; i++)
            begin
                win_reg[i] <= WINDOW_RESET[i];
            end
            refresh_reg <= REFRESH_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (reg_idx == REG_REFRESH)
            begin
                refresh_reg <= pwdata[WIN_W-1:0];
            end
            else
            begin
                win_reg[reg_idx[2:0]] <= pwdata[WIN_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (reg_idx == REG_REFRESH)
        begin
            prdata = {16'd0, refresh_reg};
        end
        else
        begin
            prdata = {16'd0, win_reg[reg_idx[2:0]]};
        end
    end

    assign in_item.mode    = mode;
    assign in_item.time_ms = time_ms;

    mwerm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    mwerm_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .WINDOW_COUNT  (WINDOW_COUNT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_item         (q_item),
        .win_len        (win_reg),
        .refresh_period (refresh_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .window_index   (window_index),
        .current_rate   (current_rate),
        .peak_rate      (peak_rate),
        .last           (last),
        .busy           (back_busy)
    );

    // A result is only shown while the back end has work in hand.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> back_busy)
        else $error("result shown while back end idle");

    // A stalled result keeps its window number.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(window_index))
        else $error("stalled result changed");

    // The current rate was once a rate of this window, so the peak covers it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> peak_rate >= current_rate)
        else $error("peak below current rate");
endmodule

[tb/multi_window_event_rate_meter_top_tb.sv]
// ============================================================================
// multi_window_event_rate_meter_top_tb
// Self-checking testbench for the multi-window event rate meter.
// ============================================================================
// A directed table of press and evaluate transfers runs first. It covers
// reset rates, time wrap and the refresh period; zero and extreme windows
// come later. Random bursts of presses and evaluates follow, over several register
// settings. Each result is compared with a predictor that keeps its own
// ring, rates and refresh time.
// ============================================================================
module multi_window_event_rate_meter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mwerm_pkg::*;

    localparam int DEPTH    = HISTORY_DEPTH_DEF;
    localparam int NWIN     = WINDOW_COUNT_DEF;
    localparam int FRAC     = FRACTION_BITS_DEF;
    localparam int IDLE_MAX = 40000;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [RATE_W-1:0] cur;
        logic [RATE_W-1:0] peak;
        logic              fin;
    } rate_result_t;

    // A row of the directed table. When chk is set, the rates are typed in
    // and are also compared with the predictor's output.
    typedef struct {
        logic              md;
        logic [TIME_W-1:0] t;
        bit                chk;
        logic [RATE_W-1:0] cur0;
        logic [RATE_W-1:0] peak0;
    } stim_row_t;

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic in_valid, in_stall, mode;
    logic [TIME_W-1:0] time_ms;
    logic out_valid, out_stall;
    logic [IDX_W-1:0] window_index;
    logic [RATE_W-1:0] current_rate, peak_rate;
    logic last;

    multi_window_event_rate_meter_top dut (.*);

    // Predictor state.
    logic [TIME_W-1:0] ring_stamps [DEPTH];
    int unsigned       ring_fill, ring_wp;
    logic [WIN_W-1:0]  win_len [NWIN];
    logic [WIN_W-1:0]  period_ms;
    logic [RATE_W-1:0] cur_rate_m [NWIN];
    logic [RATE_W-1:0] peak_rate_m [NWIN];
    logic [TIME_W-1:0] refresh_stamp;

    rate_result_t pending_rates [$];
    int  errors;
    int  idle_cycles;
    bit  quiet_out;
    bit  quiet_in;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The watchdog ends the run after a long stretch with no accepted transfer.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_MAX)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [RATE_W-1:0] rate_for(int unsigned n, logic [WIN_W-1:0] w);
        longint unsigned num, q, dv;
        num = longint'(n) * 1000 * (64'd1 << FRAC);
        dv  = (w == 0) ? 1 : w;
        q   = num / dv;
        return (q > 64'h0FFFFFFF) ? 28'hFFFFFFF : q[RATE_W-1:0];
    endfunction

    // Applies one input transfer to the predictor and queues its results.
    task automatic predict_rates(logic md, logic [TIME_W-1:0] now);
        bit refresh;
        int unsigned n, pos;
        logic [RATE_W-1:0] r;
        rate_result_t res;
        if (md == MODE_PRESS)
        begin
            ring_stamps[ring_wp] = now;
            ring_wp = (ring_wp + 1) % DEPTH;
            if (ring_fill < DEPTH)
                ring_fill++;
            return;
        end
        refresh = now > TIME_W'(refresh_stamp + period_ms);
        for (int i = 0; i < NWIN; i++)
        begin
            n = 0;
            pos = ring_wp;
            while (n < ring_fill)
            begin
                pos = (pos == 0) ? DEPTH - 1 : pos - 1;
                if (TIME_W'(ring_stamps[pos] + win_len[i]) < now)
                    break;
                n++;
            end
            r = rate_for(n, win_len[i]);
            if (r > peak_rate_m[i])
                peak_rate_m[i] = r;
            if (refresh)
                cur_rate_m[i] = r;
            res.idx  = IDX_W'(i);
            res.cur  = cur_rate_m[i];
            res.peak = peak_rate_m[i];
            res.fin  = (i == NWIN - 1);
            pending_rates.push_back(res);
        end
        if (refresh)
            refresh_stamp = now;
    endtask

    // Result side: random stalls, compared at the rising edge.
    always @(negedge clk)
        out_stall <= !quiet_out && ($urandom_range(0, 99) < 7);

    always @(posedge clk)
    begin
        rate_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rates.size() == 0)
            begin
                $error("unexpected result for window %0d", window_index);
                errors++;
            end
            else
            begin
                e = pending_rates.pop_front();
                if (window_index !== e.idx)
                begin
                    $error("window_index: expected %0d, got %0d", e.idx, window_index);
                    errors++;
                end
                if (current_rate !== e.cur)
                begin
                    $error("current_rate: expected %0d, got %0d", e.cur, current_rate);
                    errors++;
                end
                if (peak_rate !== e.peak)
                begin
                    $error("peak_rate: expected %0d, got %0d", e.peak, peak_rate);
                    errors++;
                end
                if (last !== e.fin)
                begin
                    $error("last: expected %0d, got %0d", e.fin, last);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(int idx, logic [WIN_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 5'(4 * idx);
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < NWIN)
            win_len[idx] = value;
        else
            period_ms = value;
    endtask

    // Sends one transfer; the predictor is updated once it is accepted.
    task automatic send_item(logic md, logic [TIME_W-1:0] t);
        while (!quiet_in && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= md;
        time_ms  <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_rates(md, t);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_rates.size() != 0)
            @(negedge clk);
        // Presses still in flight finish during this wait.
        repeat (20) @(negedge clk);
    endtask

    task automatic random_phase(int items);
        logic [TIME_W-1:0] base;
        int n;
        base = $urandom;
        n = 0;
        while (n < items)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                // A burst of presses close together, then an evaluate near them.
                repeat ($urandom_range(1, 12))
                begin
                    base = base + $urandom_range(0, 600);
                    send_item(MODE_PRESS, base);
                    n++;
                end
                send_item(MODE_EVAL, base + $urandom_range(0, 3000));
            end
            else
                send_item(1'($urandom_range(0, 1)), $urandom);
            n++;
        end
    endtask

    stim_row_t dir_table [$];

    initial
    begin
        rate_result_t e;
        errors = 0;
        idle_cycles = 0;
        quiet_out = 0;
        quiet_in = 0;
        rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_valid = 0; mode = MODE_PRESS; time_ms = '0; out_stall = 0;
        for (int i = 0; i < NWIN; i++)
        begin
            win_len[i] = WINDOW_RESET[i];
            cur_rate_m[i] = '0;
            peak_rate_m[i] = '0;
        end
        period_ms = REFRESH_RESET;
        ring_fill = 0;
        ring_wp = 0;
        refresh_stamp = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table: an evaluate on an empty ring gives zero rates, one
        // press at the evaluate time gives 256000/1000 for the first window.
        dir_table = '{
            '{MODE_EVAL,  32'd0,          1, 28'd0,   28'd0},
            '{MODE_EVAL,  32'hFFFFFFFF,   1, 28'd0,   28'd0},
            '{MODE_PRESS, 32'd5000,       0, 28'd0,   28'd0},
            '{MODE_EVAL,  32'd5000,       1, 28'd256, 28'd256},
            '{MODE_PRESS, 32'd5500,       0, 28'd0,   28'd0},
            '{MODE_EVAL,  32'd5550,       0, 28'd0,   28'd0},
            '{MODE_EVAL,  32'd40000,      0, 28'd0,   28'd0},
            '{MODE_PRESS, 32'hFFFFFF00,   0, 28'd0,   28'd0},
            '{MODE_PRESS, 32'hFFFFFFFF,   0, 28'd0,   28'd0},
            '{MODE_EVAL,  32'd10,         0, 28'd0,   28'd0},
            '{MODE_EVAL,  32'hFFFFFFFF,   0, 28'd0,   28'd0},
            '{MODE_PRESS, 32'h55555555,   0, 28'd0,   28'd0},
            '{MODE_PRESS, 32'hAAAAAAAA,   0, 28'd0,   28'd0},
            '{MODE_EVAL,  32'hAAAAAAAA,   0, 28'd0,   28'd0}
        };
        foreach (dir_table[k])
        begin
            send_item(dir_table[k].md, dir_table[k].t);
            if (dir_table[k].chk)
            begin
                e = pending_rates[pending_rates.size() - NWIN];
                if (e.cur !== dir_table[k].cur0)
                begin
                    $error("current_rate: expected %0d, got %0d",
                           dir_table[k].cur0, e.cur);
                    errors++;
                end
                if (e.peak !== dir_table[k].peak0)
                begin
                    $error("peak_rate: expected %0d, got %0d",
                           dir_table[k].peak0, e.peak);
                    errors++;
                end
            end
        end
        drain();

        // Extremes: zero windows, largest windows and a zero period.
        for (int i = 0; i < NWIN; i++)
            write_reg(i, (i % 2) ? 16'hFFFF : 16'h0000);
        write_reg(REG_REFRESH, 16'h0000);
        random_phase(40);
        drain();

        // A long stretch without any idling on either side.
        quiet_in = 1;
        quiet_out = 1;
        for (int i = 0; i < NWIN; i++)
            write_reg(i, WIN_W'($urandom_range(1, 65535)));
        write_reg(REG_REFRESH, 16'hFFFF);
        random_phase(40);
        drain();
        quiet_in = 0;
        quiet_out = 0;

        for (int i = 0; i < NWIN; i++)
            write_reg(i, WIN_W'($urandom_range(1, 4000)));
        write_reg(REG_REFRESH, WIN_W'($urandom_range(0, 500)));
        random_phase(45);
        drain();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
